// ===== hdl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types, constants and helper functions of the string-to-integer
// parser: character classes, parse phases and the records passed between
// the front end, the parse engine and the finishing stages.
// ----------------------------------------------------------------------------
package sip_pkg;

	localparam int OFFSET_BITS  = 16;
	localparam int OFFSET_OUT_W = 16;
	localparam int CHAR_W       = 8;
	localparam int BASE_W       = 6;
	localparam int MODE_W       = 2;
	localparam int DIGIT_W      = 6;
	localparam int VALUE_W      = 64;
	localparam int HALF_W       = 32;
	localparam int PROD_W       = VALUE_W + BASE_W;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;
	localparam int REG_SEL_BIT  = 2;

	// Character queue between the front end and the parse engine.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Result queue at the output.
	localparam int O_DEPTH = 4;
	localparam int O_PTR_W = $clog2(O_DEPTH);
	localparam int O_CNT_W = $clog2(O_DEPTH + 1);

	// Longest chain of phase changes one character can cause.
	localparam int FEED_STEPS = 5;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
	localparam logic [BASE_W-1:0] BASE_MIN  = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);
	localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);

	localparam logic [MODE_W-1:0] MODE_U32 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_U64 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_S32 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_S64 = 2'd3;

	// Register select, taken from paddr[REG_SEL_BIT].
	localparam logic REG_NUMBER_BASE = 1'b0;
	localparam logic REG_RESULT_MODE = 1'b1;

	localparam logic [BASE_W-1:0] NUMBER_BASE_RST = BASE_DEC;
	localparam logic [MODE_W-1:0] RESULT_MODE_RST = MODE_U32;

	localparam logic [VALUE_W-1:0] ALL_ONES  = '1;
	localparam logic [VALUE_W-1:0] U32_MAX   = 64'h0000_0000_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] S32_MAX   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [VALUE_W-1:0] S32_NEG   = 64'h0000_0000_8000_0000;
	localparam logic [VALUE_W-1:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] S64_NEG   = 64'h8000_0000_0000_0000;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	localparam logic [DIGIT_W-1:0] LETTER_BASE = DIGIT_W'(10);

	typedef enum logic [6:0] {
		PH_OWS    = 7'b0000001,
		PH_IWS    = 7'b0000010,
		PH_SIGN   = 7'b0000100,
		PH_PREFIX = 7'b0001000,
		PH_ZERO   = 7'b0010000,
		PH_DIGITS = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

	// Classified character as it waits in the front queue.
	typedef struct packed {
		logic               eos;
		logic               space;
		logic               plus;
		logic               minus;
		logic               zero;
		logic               xchar;
		logic               has_digit;
		logic [DIGIT_W-1:0] digit;
	} cls_t;

	// Parse state at the end of a string, handed to the finishing stages.
	typedef struct packed {
		logic [VALUE_W-1:0]     acc;
		logic                   ovf;
		logic                   seen;
		logic                   ineg;
		logic                   oneg;
		logic [MODE_W-1:0]      mode;
		logic [OFFSET_BITS-1:0] offset;
	} fin_t;

	typedef struct packed {
		logic [VALUE_W-1:0]      value;
		logic                    err;
		logic                    any;
		logic [OFFSET_OUT_W-1:0] offset;
	} res_t;

	// The terminating item behaves as a zero byte, which belongs to no class.
	function automatic cls_t classify(input logic [CHAR_W-1:0] c, input logic eos);
		cls_t r;
		r     = '0;
		r.eos = eos;
		if (!eos) begin
			r.space = c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
			r.plus  = (c == CH_PLUS);
			r.minus = (c == CH_MINUS);
			r.zero  = (c == CH_0);
			r.xchar = (c == CH_LX) || (c == CH_UX);
			if (c >= CH_0 && c <= CH_9) begin
				r.has_digit = 1'b1;
				r.digit     = DIGIT_W'(c - CH_0);
			end else if (c >= CH_LA && c <= CH_LZ) begin
				r.has_digit = 1'b1;
				r.digit     = DIGIT_W'(c - CH_LA) + LETTER_BASE;
			end else if (c >= CH_UA && c <= CH_UZ) begin
				r.has_digit = 1'b1;
				r.digit     = DIGIT_W'(c - CH_UA) + LETTER_BASE;
			end
		end
		return r;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] p);
		return (p == POS_MAX) ? p : p + 1'b1;
	endfunction

endpackage

// ===== hdl/sip_front.sv =====
// ----------------------------------------------------------------------------
// sip_front
// Front end: accepts characters, classifies them and holds them in a short
// queue until the parse engine takes them.
// ----------------------------------------------------------------------------
module sip_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [sip_pkg::CHAR_W-1:0]   char_code,
	input  logic                         end_of_string,
	output sip_pkg::cls_t                head,
	output logic                         head_valid,
	input  logic                         take
);
	import sip_pkg::*;

	cls_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               wr_en;
	logic               rd_en;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = take && head_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= classify(char_code, end_of_string);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/sip_parse.sv =====
// ----------------------------------------------------------------------------
// sip_parse
// Parse engine: walks the phase machine once per character (whitespace,
// signs, hex prefix, digits) and accumulates digits with one multiply-add
// and a carry check. At the end of a string it hands its state on.
// ----------------------------------------------------------------------------
module sip_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sip_pkg::BASE_W-1:0]   cfg_base,
	input  logic [sip_pkg::MODE_W-1:0]   cfg_mode,
	input  sip_pkg::cls_t                head,
	input  logic                         head_valid,
	input  logic                         room,
	output logic                         take,
	output logic                         fin_valid_s1,
	output sip_pkg::fin_t                fin_s1
);
	import sip_pkg::*;

	phase_t                 phase_q;
	logic                   oneg_q;
	logic                   ineg_q;
	logic [VALUE_W-1:0]     acc_q;
	logic                   ovf_q;
	logic                   seen_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] saved_q;
	logic [BASE_W-1:0]      ebase_q;

	phase_t                 ph_n;
	logic                   oneg_n;
	logic                   ineg_n;
	logic [VALUE_W-1:0]     acc_n;
	logic                   ovf_n;
	logic                   seen_n;
	logic [OFFSET_BITS-1:0] saved_n;
	logic [BASE_W-1:0]      eb_n;
	logic                   again;
	logic                   do_acc;
	logic                   signed_mode;
	logic                   digit_ok;
	logic [PROD_W-1:0]      prod;

	// A string end needs a free slot further down; plain characters never wait.
	assign take        = head_valid && (!head.eos || room);
	assign signed_mode = (cfg_mode == MODE_S32) || (cfg_mode == MODE_S64);

	always_comb begin
		ph_n    = phase_q;
		oneg_n  = oneg_q;
		ineg_n  = ineg_q;
		seen_n  = seen_q;
		saved_n = saved_q;
		eb_n    = (phase_q == PH_OWS && pos_q == '0) ? cfg_base : ebase_q;
		again   = 1'b1;
		do_acc  = 1'b0;
		for (int i = 0; i < FEED_STEPS; i++) begin
			if (again) begin
				again = 1'b0;
				case (ph_n)
					PH_OWS: begin
						if (!head.space) begin
							if (signed_mode) begin
								if (head.plus || head.minus) begin
									oneg_n  = head.minus;
									saved_n = pos_inc(pos_q);
								end else begin
									saved_n = pos_q;
									again   = 1'b1;
								end
								ph_n = PH_IWS;
							end else begin
								saved_n = pos_q;
								ph_n    = PH_SIGN;
								again   = 1'b1;
							end
						end
					end
					PH_IWS: begin
						if (!head.space) begin
							saved_n = (pos_q == saved_n) ? '0 : pos_q;
							ph_n    = PH_SIGN;
							again   = 1'b1;
						end
					end
					PH_SIGN: begin
						ph_n = PH_PREFIX;
						if (head.minus) begin
							ineg_n = 1'b1;
						end else if (!head.plus) begin
							again = 1'b1;
						end
					end
					PH_PREFIX: begin
						if ((eb_n == BASE_AUTO || eb_n == BASE_HEX) && head.zero) begin
							ph_n = PH_ZERO;
						end else begin
							if (eb_n == BASE_AUTO) begin
								eb_n = BASE_DEC;
							end
							ph_n  = PH_DIGITS;
							again = 1'b1;
						end
					end
					PH_ZERO: begin
						// The leading zero counts as a digit of value zero; the
						// accumulator is still zero, so only the flag changes.
						if (head.xchar) begin
							eb_n = BASE_HEX;
						end else begin
							if (eb_n == BASE_AUTO) begin
								eb_n = BASE_DEC;
							end
							seen_n = 1'b1;
							again  = 1'b1;
						end
						ph_n = PH_DIGITS;
					end
					PH_DIGITS: begin
						if (head.has_digit && BASE_W'(head.digit) < eb_n &&
								eb_n >= BASE_MIN && eb_n <= BASE_MAX) begin
							do_acc = 1'b1;
						end else begin
							if (seen_n) begin
								saved_n = pos_q;
							end
							ph_n = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign digit_ok = do_acc;
	assign prod     = PROD_W'(acc_q) * PROD_W'(eb_n) + PROD_W'(head.digit);

	always_comb begin
		acc_n = acc_q;
		ovf_n = ovf_q;
		if (digit_ok) begin
			if (!ovf_q) begin
				if (prod[PROD_W-1:VALUE_W] != '0) begin
					ovf_n = 1'b1;
					acc_n = ALL_ONES;
				end else begin
					acc_n = prod[VALUE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OWS;
			oneg_q       <= 1'b0;
			ineg_q       <= 1'b0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
			seen_q       <= 1'b0;
			pos_q        <= '0;
			saved_q      <= '0;
			ebase_q      <= BASE_DEC;
			fin_valid_s1 <= 1'b0;
		end else begin
			fin_valid_s1 <= take && head.eos;
			if (take) begin
				ebase_q <= eb_n;
				if (head.eos) begin
					phase_q <= PH_OWS;
					oneg_q  <= 1'b0;
					ineg_q  <= 1'b0;
					acc_q   <= '0;
					ovf_q   <= 1'b0;
					seen_q  <= 1'b0;
					pos_q   <= '0;
					saved_q <= '0;
				end else begin
					phase_q <= ph_n;
					oneg_q  <= oneg_n;
					ineg_q  <= ineg_n;
					acc_q   <= acc_n;
					ovf_q   <= ovf_n;
					seen_q  <= seen_n || digit_ok;
					pos_q   <= pos_inc(pos_q);
					saved_q <= saved_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head.eos) begin
			fin_s1.acc    <= acc_n;
			fin_s1.ovf    <= ovf_n;
			fin_s1.seen   <= seen_n || digit_ok;
			fin_s1.ineg   <= ineg_n;
			fin_s1.oneg   <= oneg_n;
			fin_s1.mode   <= cfg_mode;
			fin_s1.offset <= saved_n;
		end
	end

endmodule

// ===== hdl/sip_finish.sv =====
// ----------------------------------------------------------------------------
// sip_finish
// Finishing stages: negation and 32-bit clamp, then the signed-range clamp
// and sign extension, then the result queue that faces the consumer.
// ----------------------------------------------------------------------------
module sip_finish (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fin_valid_s1,
	input  sip_pkg::fin_t                fin_s1,
	output logic                         room,
	output logic                         empty,
	input  logic                         pop,
	output sip_pkg::res_t                res
);
	import sip_pkg::*;

	logic                   valid_s2;
	logic [VALUE_W-1:0]     u_s2;
	logic                   err_s2;
	logic                   oneg_s2;
	logic                   seen_s2;
	logic [MODE_W-1:0]      mode_s2;
	logic [OFFSET_BITS-1:0] offset_s2;

	logic [VALUE_W-1:0]     u_c;
	logic                   err_c;
	logic                   wide_s1;

	logic [VALUE_W-1:0]     v_c;
	logic                   verr_c;
	logic                   wide_s2;
	logic                   signed_s2;
	logic [VALUE_W-1:0]     pmax;
	logic [VALUE_W-1:0]     pneg;

	res_t                   mem_q [O_DEPTH];
	logic [O_PTR_W-1:0]     wr_ptr_q;
	logic [O_PTR_W-1:0]     rd_ptr_q;
	logic [O_CNT_W-1:0]     cnt_q;
	logic [O_CNT_W:0]       busy;
	logic                   rd_en;

	assign wide_s1 = (fin_s1.mode == MODE_U64) || (fin_s1.mode == MODE_S64);

	always_comb begin
		err_c = fin_s1.ovf;
		u_c   = fin_s1.ineg ? (VALUE_W'(0) - fin_s1.acc) : fin_s1.acc;
		if (!wide_s1) begin
			if (!fin_s1.ineg && fin_s1.acc[VALUE_W-1:HALF_W] != '0) begin
				err_c = 1'b1;
				u_c   = U32_MAX;
			end
			u_c[VALUE_W-1:HALF_W] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid_s1) begin
			u_s2      <= u_c;
			err_s2    <= err_c;
			oneg_s2   <= fin_s1.oneg;
			seen_s2   <= fin_s1.seen;
			mode_s2   <= fin_s1.mode;
			offset_s2 <= fin_s1.offset;
		end
	end

	assign wide_s2   = (mode_s2 == MODE_U64) || (mode_s2 == MODE_S64);
	assign signed_s2 = (mode_s2 == MODE_S32) || (mode_s2 == MODE_S64);
	assign pmax      = wide_s2 ? S64_MAX : S32_MAX;
	assign pneg      = wide_s2 ? S64_NEG : S32_NEG;

	always_comb begin
		v_c    = u_s2;
		verr_c = err_s2;
		if (signed_s2) begin
			if (!oneg_s2) begin
				if (u_s2 > pmax) begin
					verr_c = 1'b1;
					v_c    = pmax;
				end
			end else begin
				if (u_s2 > pneg) begin
					verr_c = 1'b1;
					v_c    = pneg;
				end else begin
					v_c = VALUE_W'(0) - u_s2;
				end
			end
			if (!wide_s2) begin
				v_c[VALUE_W-1:HALF_W] = {HALF_W{v_c[HALF_W-1]}};
			end
		end
		if (!seen_s2) begin
			v_c    = '0;
			verr_c = 1'b0;
		end
	end

	// Results in flight count against the queue, so a finished result
	// always finds a free slot.
	assign busy  = (O_CNT_W + 1)'(cnt_q) + (O_CNT_W + 1)'(fin_valid_s1) +
		(O_CNT_W + 1)'(valid_s2);
	assign room  = (busy < (O_CNT_W + 1)'(O_DEPTH));
	assign empty = (cnt_q == '0);
	assign res   = mem_q[rd_ptr_q];
	assign rd_en = pop && !empty;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			mem_q[wr_ptr_q] <= '{value: v_c, err: verr_c, any: seen_s2,
				offset: OFFSET_OUT_W'(offset_s2)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s2) begin
				wr_ptr_q <= (wr_ptr_q == O_PTR_W'(O_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == O_PTR_W'(O_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (valid_s2 && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !valid_s2) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/string_to_integer_parser.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming string-to-integer converter: one character per transfer, one
// result per string, with whitespace, signs, hex prefix, saturation and
// range clamping for 32/64-bit unsigned and signed results.
//
//   channel   direction  handshake           contents
//   input     in         push / full         char_code, end_of_string
//   result    out        pop / empty         value_bits, range_error,
//                                            any_digits, end_offset
//   config    in/out     APB psel/penable    number_base, result_mode
//
// A character is taken every cycle while full is low; the per-character
// multiply-add on the 64-bit accumulator is the loop that sets that rate.
// After its end-of-string transfer a result passes the front queue, the
// parse engine's fin_s1 register and the s2 finishing stage, and is then
// written into the result queue.
// Both queues are four deep; full rises only when the parse engine stalls
// on a string end for want of a free result slot.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module string_to_integer_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sip_pkg::CHAR_W-1:0]        char_code,
	input  logic                              end_of_string,
	output logic                              empty,
	input  logic                              pop,
	output logic [sip_pkg::VALUE_W-1:0]       value_bits,
	output logic                              range_error,
	output logic                              any_digits,
	output logic [sip_pkg::OFFSET_OUT_W-1:0]  end_offset,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sip_pkg::ADDR_W-1:0]        paddr,
	input  logic [sip_pkg::DATA_W-1:0]        pwdata,
	output logic [sip_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import sip_pkg::*;

	logic [BASE_W-1:0] number_base_q;
	logic [MODE_W-1:0] result_mode_q;
	logic              cfg_wr;

	cls_t              head;
	logic              head_valid;
	logic              take;
	logic              room;
	logic              fin_valid_s1;
	fin_t              fin_s1;
	res_t              res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[REG_SEL_BIT] == REG_RESULT_MODE) ? DATA_W'(result_mode_q)
		: DATA_W'(number_base_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= NUMBER_BASE_RST;
			result_mode_q <= RESULT_MODE_RST;
		end else if (cfg_wr) begin
			case (paddr[REG_SEL_BIT])
				REG_NUMBER_BASE: number_base_q <= pwdata[BASE_W-1:0];
				REG_RESULT_MODE: result_mode_q <= pwdata[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.head          (head),
		.head_valid    (head_valid),
		.take          (take)
	);

	sip_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_base     (number_base_q),
		.cfg_mode     (result_mode_q),
		.head         (head),
		.head_valid   (head_valid),
		.room         (room),
		.take         (take),
		.fin_valid_s1 (fin_valid_s1),
		.fin_s1       (fin_s1)
	);

	sip_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin_valid_s1 (fin_valid_s1),
		.fin_s1       (fin_s1),
		.room         (room),
		.empty        (empty),
		.pop          (pop),
		.res          (res)
	);

	assign value_bits  = res.value;
	assign range_error = res.err;
	assign any_digits  = res.any;
	assign end_offset  = res.offset;

	// A string end leaves the parse engine only when a result slot was free.
	a_room_before_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_s1 |-> $past(room))
		else $error("string end finished without a free result slot");

	// With no digit the result is zero and carries no range error.
	a_no_digits_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !any_digits) |-> (value_bits == '0 && !range_error))
		else $error("result without digits is not clean");

	// Signed 32-bit results are sign-extended to the full width.
	a_s32_extended: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_mode_q == MODE_S32) |->
			(value_bits[VALUE_W-1:HALF_W] == {HALF_W{value_bits[HALF_W-1]}}))
		else $error("signed 32-bit result not sign-extended");

	// Unsigned 32-bit results have a clear upper half.
	a_u32_zero_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_mode_q == MODE_U32) |-> (value_bits[VALUE_W-1:HALF_W] == '0))
		else $error("unsigned 32-bit result has upper bits set");

endmodule

// ===== verif/string_to_integer_parser_test.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_test
// Self-checking testbench for the streaming string-to-integer parser. A table
// of short strings covers the extremes and corner cases of parsing, followed
// by a stretch with a stalled result side and then random strings under
// changing base and mode settings. Each result is compared with the table's
// expected value where the row gives one, else with a behavioral parser.
// ----------------------------------------------------------------------------
module string_to_integer_parser_test;

	import sip_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 10;
	localparam int IDLE_PCT       = 36;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_ITEMS   = 1360;
	localparam int STALL_CYCLES   = 300;
	localparam int TIMEOUT_CYCLES = 1_500_000;
	localparam int DIRECTED_ROWS  = 23;

	localparam logic [ADDR_W-1:0] ADDR_NUMBER_BASE = ADDR_W'(REG_NUMBER_BASE) << REG_SEL_BIT;
	localparam logic [ADDR_W-1:0] ADDR_RESULT_MODE = ADDR_W'(REG_RESULT_MODE) << REG_SEL_BIT;

	// A string variable cannot hold a zero byte, so '@' in a table row stands for one.
	localparam logic [CHAR_W-1:0] ZERO_MARK = 8'h40;

	localparam logic [BASE_W-1:0] BASE_PICKS [7] = '{BASE_AUTO, 6'd1, BASE_MIN, 6'd8,
		BASE_DEC, BASE_HEX, BASE_MAX};
	localparam logic [CHAR_W-1:0] SPACE_CHARS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT,
		CH_FF, CH_CR};

	typedef struct {
		logic [BASE_W-1:0] base;
		logic [MODE_W-1:0] mode;
		int                pad;
		string             text;
		bit                known;
		res_t              want;
	} parse_case_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    push          = 1'b0;
	logic                    full;
	logic [CHAR_W-1:0]       char_code     = '0;
	logic                    end_of_string = 1'b0;
	logic                    empty;
	logic                    pop           = 1'b0;
	logic [VALUE_W-1:0]      value_bits;
	logic                    range_error;
	logic                    any_digits;
	logic [OFFSET_OUT_W-1:0] end_offset;
	logic                    psel          = 1'b0;
	logic                    penable       = 1'b0;
	logic                    pwrite        = 1'b0;
	logic [ADDR_W-1:0]       paddr         = '0;
	logic [DATA_W-1:0]       pwdata        = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	res_t pending_results [$];
	int   fail_count   = 0;
	int   idle_pct     = IDLE_PCT;
	int   hold_request = 0;

	// Shadow parser: settings and per-string state.
	logic [BASE_W-1:0]      cfg_base;
	logic [MODE_W-1:0]      cfg_mode;
	phase_t                 scan_phase;
	bit                     neg_outer;
	bit                     neg_inner;
	logic [VALUE_W-1:0]     acc;
	bit                     acc_sat;
	bit                     got_digit;
	logic [OFFSET_BITS-1:0] pos;
	logic [OFFSET_BITS-1:0] mark;
	logic [BASE_W-1:0]      radix;

	parse_case_t directed_rows [DIRECTED_ROWS] = '{
		'{BASE_DEC, MODE_U32, 0, "", 1'b1, '{64'd0, 1'b0, 1'b0, 16'd0}},
		'{BASE_DEC, MODE_U32, 0, "4294967295", 1'b1, '{U32_MAX, 1'b0, 1'b1, 16'd10}},
		'{BASE_DEC, MODE_U32, 0, "4294967296", 1'b1, '{U32_MAX, 1'b1, 1'b1, 16'd10}},
		'{BASE_DEC, MODE_U64, 0, "18446744073709551616", 1'b1,
			'{ALL_ONES, 1'b1, 1'b1, 16'd20}},
		'{BASE_DEC, MODE_U64, 0, "-99999999999999999999", 1'b1,
			'{64'd1, 1'b1, 1'b1, 16'd21}},
		'{BASE_DEC, MODE_U32, 0, "-1", 1'b1, '{U32_MAX, 1'b0, 1'b1, 16'd2}},
		'{BASE_DEC, MODE_S32, 0, "-2147483648", 1'b1,
			'{64'hFFFF_FFFF_8000_0000, 1'b0, 1'b1, 16'd11}},
		'{BASE_DEC, MODE_S32, 0, "2147483648", 1'b1, '{S32_MAX, 1'b1, 1'b1, 16'd10}},
		'{BASE_DEC, MODE_S64, 0, "-9223372036854775809", 1'b1,
			'{S64_NEG, 1'b1, 1'b1, 16'd20}},
		'{BASE_HEX, MODE_U64, 0, "0xFFffFFffFFffFFff", 1'b1,
			'{ALL_ONES, 1'b0, 1'b1, 16'd18}},
		'{BASE_AUTO, MODE_U32, 0, "0x", 1'b1, '{64'd0, 1'b0, 1'b0, 16'd0}},
		'{BASE_AUTO, MODE_U32, 0, " 017", 1'b0, '0},
		'{BASE_MIN, MODE_U32, 0, "1012", 1'b1, '{64'd5, 1'b0, 1'b1, 16'd3}},
		'{BASE_MAX, MODE_U64, 0, "zZ", 1'b1, '{64'd1295, 1'b0, 1'b1, 16'd2}},
		'{6'd1, MODE_U32, 0, "5", 1'b1, '{64'd0, 1'b0, 1'b0, 16'd0}},
		'{BASE_DEC, MODE_S32, 0, "\t- +42", 1'b0, '0},
		'{BASE_DEC, MODE_S64, 0, "\v+ ", 1'b0, '0},
		'{BASE_DEC, MODE_S64, 0, "-x", 1'b0, '0},
		'{BASE_DEC, MODE_U32, 0, "@7", 1'b0, '0},
		'{BASE_DEC, MODE_U32, 0, "12abc", 1'b0, '0},
		'{BASE_HEX, MODE_U32, 0, "-0X10", 1'b0, '0},
		'{BASE_HEX, MODE_U32, 0, "+0", 1'b0, '0},
		// Leading blanks ahead of a single digit.
		'{BASE_DEC, MODE_U64, 3, "7", 1'b1, '{64'd7, 1'b0, 1'b1, 16'd4}}
	};

	string_to_integer_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.value_bits    (value_bits),
		.range_error   (range_error),
		.any_digits    (any_digits),
		.end_offset    (end_offset),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit is_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
			c == CH_CR;
	endfunction

	function automatic int char_digit(input logic [CHAR_W-1:0] c, input logic [BASE_W-1:0] b);
		int d;
		d = -1;
		if (c >= CH_0 && c <= CH_9) begin
			d = int'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = int'(c - CH_LA) + 10;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = int'(c - CH_UA) + 10;
		end
		if (b < BASE_MIN || b > BASE_MAX || d >= int'(b)) begin
			d = -1;
		end
		return d;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] next_pos(input logic [OFFSET_BITS-1:0] p);
		return (p == POS_MAX) ? p : p + 1'b1;
	endfunction

	function automatic void clear_parse();
		scan_phase = PH_OWS;
		neg_outer  = 1'b0;
		neg_inner  = 1'b0;
		acc        = '0;
		acc_sat    = 1'b0;
		got_digit  = 1'b0;
		pos        = '0;
		mark       = '0;
	endfunction

	// Once the accumulator has saturated it stays at all ones.
	function automatic void add_digit(input int d);
		logic [VALUE_W-1:0] dd;
		logic [VALUE_W-1:0] bb;
		dd        = VALUE_W'(d);
		bb        = VALUE_W'(radix);
		got_digit = 1'b1;
		if (!acc_sat && radix >= BASE_MIN) begin
			if (acc > (ALL_ONES - dd) / bb) begin
				acc_sat = 1'b1;
				acc     = ALL_ONES;
			end else begin
				acc = acc * bb + dd;
			end
		end
	endfunction

	// One character may pass through several phases before it is consumed.
	function automatic void feed_char(input logic [CHAR_W-1:0] c,
		input logic [OFFSET_BITS-1:0] here, input bit signed_mode);
		bit again;
		int d;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (scan_phase)
				PH_OWS: begin
					if (!is_space(c)) begin
						if (signed_mode) begin
							if (c == CH_PLUS || c == CH_MINUS) begin
								neg_outer = (c == CH_MINUS);
								mark      = next_pos(here);
							end else begin
								mark  = here;
								again = 1'b1;
							end
							scan_phase = PH_IWS;
						end else begin
							mark       = here;
							scan_phase = PH_SIGN;
							again      = 1'b1;
						end
					end
				end
				PH_IWS: begin
					if (!is_space(c)) begin
						mark       = (here == mark) ? '0 : here;
						scan_phase = PH_SIGN;
						again      = 1'b1;
					end
				end
				PH_SIGN: begin
					scan_phase = PH_PREFIX;
					if (c == CH_MINUS) begin
						neg_inner = 1'b1;
					end else if (c != CH_PLUS) begin
						again = 1'b1;
					end
				end
				PH_PREFIX: begin
					if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_0) begin
						scan_phase = PH_ZERO;
					end else begin
						if (radix == BASE_AUTO) begin
							radix = BASE_DEC;
						end
						scan_phase = PH_DIGITS;
						again      = 1'b1;
					end
				end
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						radix = BASE_HEX;
					end else begin
						if (radix == BASE_AUTO) begin
							radix = BASE_DEC;
						end
						add_digit(0);
						again = 1'b1;
					end
					scan_phase = PH_DIGITS;
				end
				PH_DIGITS: begin
					d = char_digit(c, radix);
					if (d >= 0) begin
						add_digit(d);
					end else begin
						if (got_digit) begin
							mark = here;
						end
						scan_phase = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	endfunction

	// Returns 1 when the character ends a string; the result is then in r.
	function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic eos,
		output res_t r);
		logic [VALUE_W-1:0] u;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] top;
		bit                 wide;
		bit                 signed_mode;
		wide        = (cfg_mode == MODE_U64 || cfg_mode == MODE_S64);
		signed_mode = (cfg_mode == MODE_S32 || cfg_mode == MODE_S64);
		u           = '0;
		v           = '0;
		r           = '0;
		if (scan_phase == PH_OWS && pos == '0) begin
			radix = cfg_base;
		end
		if (!eos) begin
			feed_char(c, pos, signed_mode);
			pos = next_pos(pos);
			return 1'b0;
		end
		feed_char(8'h00, pos, signed_mode);
		if (got_digit) begin
			r.err = acc_sat;
			u     = neg_inner ? VALUE_W'(0) - acc : acc;
			if (!wide) begin
				if (!neg_inner && acc > U32_MAX) begin
					r.err = 1'b1;
					u     = U32_MAX;
				end
				u &= U32_MAX;
			end
			if (!signed_mode) begin
				v = u;
			end else begin
				top = wide ? S64_MAX : S32_MAX;
				if (!neg_outer) begin
					if (u > top) begin
						r.err = 1'b1;
						v     = top;
					end else begin
						v = u;
					end
				end else if (u > top + 1'b1) begin
					r.err = 1'b1;
					v     = top + 1'b1;
				end else begin
					v = VALUE_W'(0) - u;
				end
				if (!wide) begin
					v &= U32_MAX;
					if (v[HALF_W-1]) begin
						v[VALUE_W-1:HALF_W] = '1;
					end
				end
			end
		end
		r.value  = v;
		r.any    = got_digit;
		r.offset = mark;
		clear_parse();
		return 1'b1;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("mismatch %0d: %s", fail_count, what);
		end
	endtask

	// Push stays high from one transfer to the next unless an idle cycle comes between.
	task automatic send_item(input logic [CHAR_W-1:0] c, input logic eos, input bit known,
		input res_t want);
		res_t got;
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		char_code     <= c;
		end_of_string <= eos;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		if (parse_char(c, eos, got)) begin
			pending_results.push_back(known ? want : got);
		end
	endtask

	task automatic stop_sending();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Settings change only between strings, once the block has drained.
	task automatic apply_setting(input logic [BASE_W-1:0] b, input logic [MODE_W-1:0] m);
		stop_sending();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ADDR_NUMBER_BASE, DATA_W'(b));
		write_reg(ADDR_RESULT_MODE, DATA_W'(m));
		cfg_base = b;
		cfg_mode = m;
	endtask

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Verification failed");
		$finish;
	end

	// Result side: random pops, plus one long hold-off counted here.
	initial begin
		int   stall_left;
		res_t want;
		stall_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request != 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= ($urandom_range(99) >= idle_pct);
			end
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					note_failure($sformatf("result with nothing expected: value %h offset %0d",
						value_bits, end_offset));
				end else begin
					want = pending_results.pop_front();
					if (value_bits !== want.value || range_error !== want.err ||
						any_digits !== want.any || end_offset !== want.offset) begin
						note_failure($sformatf(
							"expected value %h err %b any %b offset %0d, got %h %b %b %0d",
							want.value, want.err, want.any, want.offset,
							value_bits, range_error, any_digits, end_offset));
					end
				end
			end
		end
	end

	initial begin
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] body [$];
		logic [CHAR_W-1:0] tail [$];
		logic [BASE_W-1:0] pick_base;
		int                sent;
		int                gen_radix;
		int                digit_count;
		int                d;
		int                roll;

		cfg_base = NUMBER_BASE_RST;
		cfg_mode = RESULT_MODE_RST;
		radix    = BASE_DEC;
		clear_parse();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].base != cfg_base || directed_rows[r].mode != cfg_mode) begin
				apply_setting(directed_rows[r].base, directed_rows[r].mode);
			end
			repeat (directed_rows[r].pad) send_item(CH_SPACE, 1'b0, 1'b0, '0);
			for (int k = 0; k < directed_rows[r].text.len(); k++) begin
				ch = directed_rows[r].text[k];
				if (ch == ZERO_MARK) begin
					ch = 8'h00;
				end
				send_item(ch, 1'b0, 1'b0, '0);
			end
			send_item(CHAR_W'($urandom_range(255)), 1'b1, directed_rows[r].known,
				directed_rows[r].want);
		end

		// Fill both queues behind a stalled result side, then drain completely.
		apply_setting(BASE_DEC, MODE_S64);
		hold_request = STALL_CYCLES;
		for (int k = 0; k < 24; k++) begin
			send_item(CH_0 + CHAR_W'(k % 10), 1'b0, 1'b0, '0);
			send_item(CHAR_W'($urandom_range(255)), 1'b1, 1'b0, '0);
		end
		stop_sending();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end

		sent = 0;
		for (int s = 0; sent < RANDOM_ITEMS; s++) begin
			if (s % 10 == 0) begin
				pick_base = $urandom_range(1) ? BASE_PICKS[$urandom_range(6)] :
					BASE_W'($urandom_range(36));
				apply_setting(pick_base, MODE_W'($urandom_range(3)));
			end
			idle_pct = (s >= 40 && s < 70) ? 0 : IDLE_PCT;
			body.delete();
			tail.delete();
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(8)) body.push_back(CHAR_W'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(3)) body.push_back(SPACE_CHARS[$urandom_range(5)]);
				case ($urandom_range(2))
					0: body.push_back(CH_PLUS);
					1: body.push_back(CH_MINUS);
					default: begin
					end
				endcase
				if ((cfg_mode == MODE_S32 || cfg_mode == MODE_S64) &&
					$urandom_range(99) < 30) begin
					repeat ($urandom_range(2)) body.push_back(SPACE_CHARS[$urandom_range(5)]);
					case ($urandom_range(2))
						0: body.push_back(CH_PLUS);
						1: body.push_back(CH_MINUS);
						default: begin
						end
					endcase
				end
				gen_radix = int'(cfg_base);
				if ((cfg_base == BASE_AUTO || cfg_base == BASE_HEX) &&
					$urandom_range(99) < 45) begin
					body.push_back(CH_0);
					body.push_back($urandom_range(1) ? CH_LX : CH_UX);
					gen_radix = 16;
				end else if ($urandom_range(99) < 12) begin
					body.push_back(CH_0);
				end
				if (gen_radix == 0) begin
					gen_radix = 10;
				end
				// Long digit runs reach saturation, small bases need many more digits.
				roll = $urandom_range(99);
				if (roll < 8) begin
					digit_count = 0;
				end else if (roll < 75) begin
					digit_count = $urandom_range(6, 1);
				end else if (gen_radix <= 4) begin
					digit_count = $urandom_range(70, 20);
				end else begin
					digit_count = $urandom_range(24, 7);
				end
				repeat (digit_count) begin
					if ($urandom_range(99) < 4) begin
						body.push_back(CHAR_W'($urandom_range(255)));
					end else if (gen_radix < 2 || gen_radix > 36) begin
						body.push_back(CH_0 + CHAR_W'($urandom_range(9)));
					end else begin
						d = $urandom_range(gen_radix - 1);
						if (d < 10) begin
							body.push_back(CH_0 + CHAR_W'(d));
						end else begin
							body.push_back(($urandom_range(1) ? CH_LA : CH_UA) +
								CHAR_W'(d - 10));
						end
					end
				end
				if ($urandom_range(99) < 30) begin
					repeat ($urandom_range(3, 1)) tail.push_back(CHAR_W'($urandom_range(255)));
				end
			end
			foreach (body[k]) begin
				send_item(body[k], 1'b0, 1'b0, '0);
			end
			foreach (tail[k]) begin
				send_item(tail[k], 1'b0, 1'b0, '0);
			end
			send_item(CHAR_W'($urandom_range(255)), 1'b1, 1'b0, '0);
			sent += body.size() + 1;
		end

		stop_sending();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== string_to_integer_parser.f =====
hdl/sip_pkg.sv
hdl/sip_front.sv
hdl/sip_parse.sv
hdl/sip_finish.sv
hdl/string_to_integer_parser.sv
verif/string_to_integer_parser_test.sv
